### rtl/core/tst_pkg.sv
`timescale 1ns / 1ps

package tst_pkg;

    // Default sizing, handed to the top level parameters as their defaults
    localparam int SLOTS_DEF      = 16;
    localparam int STAMP_BITS_DEF = 32;

    // Fixed field widths of the stream words
    localparam int OP_W        = 3;
    localparam int IDX_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int SEQ_W       = 8;
    localparam int NOW_W       = 32;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    // Slot status codes
    localparam logic [STATUS_W-1:0] ST_FREE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PENDING = 3'd1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT       = 3'd0,
        OP_ALLOC      = 3'd1,
        OP_FREE       = 3'd2,
        OP_SET_STATUS = 3'd3,
        OP_SET_SEQ    = 3'd4,
        OP_OLDEST     = 3'd5,
        OP_FIND_SEQ   = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_DONE
    } t_state;

    // Search key shared by the sequencer and the compare unit
    typedef struct packed {
        t_opcode             op;
        logic [STATUS_W-1:0] status;
        logic [SEQ_W-1:0]    seq;
        logic [IDX_W-1:0]    skip;
        logic                skip_on;
    } t_cmp_key;

endpackage

### rtl/core/tst_ram.sv
`timescale 1ns / 1ps

module tst_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tst_cmp.sv
`timescale 1ns / 1ps

module tst_cmp #(
    parameter int IW         = 4,
    parameter int STAMP_BITS = tst_pkg::STAMP_BITS_DEF
) (
    input  tst_pkg::t_cmp_key              i_key,
    input  logic [IW-1:0]                  i_row_idx,
    input  logic [tst_pkg::STATUS_W-1:0]   i_row_status,
    input  logic [tst_pkg::SEQ_W-1:0]      i_row_seq,
    input  logic [STAMP_BITS-1:0]          i_row_stamp,
    input  logic                           i_best_found,
    input  logic [STAMP_BITS-1:0]          i_best_stamp,
    output logic                           o_take
);

    localparam int CW = ((IW > tst_pkg::IDX_W) ? IW : tst_pkg::IDX_W) + 1;

    logic w_skipped;
    logic w_older;

    // Skip index beyond the pool never equals a real slot
    assign w_skipped = i_key.skip_on && (CW'(i_row_idx) == CW'(i_key.skip));
    // Strict compare keeps the lowest index on a tie
    assign w_older   = !i_best_found || (i_row_stamp < i_best_stamp);

    // One slot per call: decide whether it replaces the current pick
    always_comb begin
        o_take = 1'b0;
        unique case (i_key.op)
            tst_pkg::OP_ALLOC: begin
                o_take = !i_best_found && (i_row_status == tst_pkg::ST_FREE);
            end
            tst_pkg::OP_OLDEST: begin
                o_take = (i_row_status == i_key.status) && w_older;
            end
            tst_pkg::OP_FIND_SEQ: begin
                o_take = !i_best_found && !w_skipped &&
                         (i_row_status != tst_pkg::ST_FREE) &&
                         (i_row_seq == i_key.seq);
            end
            default: begin
                o_take = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/transaction_slot_table.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   tuser: opcode; tdata: slot, status, seq, skip, now
// m        out  o_m_tvalid/i_m_tready   tuser: found;  tdata: result index
//
// Search opcodes (alloc, get oldest, find sequence) scan the whole pool for each word:
// the scan reads one slot per cycle from the slot RAMs through a single compare unit.
// Other opcodes go straight to write-back. A new word is taken only while the sequencer is idle.
// Reset (i_rst_n low, synchronous) frees every slot at once through per-slot valid bits.
// A stalled result waits in the output register; the scan of a following word is held
// at its end until that register frees up.

module transaction_slot_table #(
    parameter int SLOTS      = tst_pkg::SLOTS_DEF,
    parameter int STAMP_BITS = tst_pkg::STAMP_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [3:0] slot_index, [6:4] status_code, [14:7] seq_number, [18:15] skip_index,
    // [19] skip_valid, [51:20] now, [55:52] zero
    input  logic [tst_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // [2:0] opcode
    input  logic [tst_pkg::OP_W-1:0]          i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [3:0] result_index, [7:4] zero
    output logic [tst_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // [0] found
    output logic                              o_m_tuser
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = ((IW > tst_pkg::IDX_W) ? IW : tst_pkg::IDX_W) + 1;
    localparam int SW = tst_pkg::STATUS_W;
    localparam int QW = tst_pkg::SEQ_W;

    tst_pkg::t_state   r_state, n_state;
    tst_pkg::t_cmp_key r_key;
    logic [tst_pkg::IDX_W-1:0] r_slot;
    logic [STAMP_BITS-1:0]     r_now;
    logic [IW-1:0]             r_cnt;

    logic                  r_pipe_vld;
    logic [IW-1:0]         r_pipe_idx;
    logic                  r_pipe_stv, r_pipe_sqv, r_pipe_tmv;

    logic                  r_found;
    logic [IW-1:0]         r_hit;
    logic [STAMP_BITS-1:0] r_best_stamp;

    logic [SLOTS-1:0]      r_st_vld, r_sq_vld, r_tm_vld;

    logic                  r_out_vld;
    logic                  r_out_found;
    logic [tst_pkg::IDX_W-1:0] r_out_idx;

    logic                  w_accept, w_out_free, w_take, w_in_range;
    logic [CW-1:0]         w_slot_ext, w_hit_ext;
    logic [SW-1:0]         w_st_q, w_row_status;
    logic [QW-1:0]         w_sq_q, w_row_seq;
    logic [STAMP_BITS-1:0] w_tm_q, w_row_stamp;

    logic                  st_we, sq_we, tm_we, init_clr;
    logic [IW-1:0]         waddr;
    logic [SW-1:0]         st_wdata;
    logic [QW-1:0]         sq_wdata;
    logic [STAMP_BITS-1:0] tm_wdata;

    assign o_s_tready = (r_state == tst_pkg::S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_vld || i_m_tready;

    assign w_slot_ext = CW'(r_slot);
    assign w_in_range = (w_slot_ext < CW'(SLOTS));
    assign w_hit_ext  = CW'(r_hit);

    // Slot stores, one read per scan cycle
    tst_ram #(.W(SW), .DEPTH(SLOTS)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_st_q)
    );

    tst_ram #(.W(QW), .DEPTH(SLOTS)) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (waddr),
        .i_wdata (sq_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_sq_q)
    );

    tst_ram #(.W(STAMP_BITS), .DEPTH(SLOTS)) u_tm_ram (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (waddr),
        .i_wdata (tm_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_tm_q)
    );

    // Entries never written read as their reset value
    assign w_row_status = r_pipe_stv ? w_st_q : tst_pkg::ST_FREE;
    assign w_row_seq    = r_pipe_sqv ? w_sq_q : '0;
    assign w_row_stamp  = r_pipe_tmv ? w_tm_q : '0;

    tst_cmp #(.IW(IW), .STAMP_BITS(STAMP_BITS)) u_cmp (
        .i_key        (r_key),
        .i_row_idx    (r_pipe_idx),
        .i_row_status (w_row_status),
        .i_row_seq    (w_row_seq),
        .i_row_stamp  (w_row_stamp),
        .i_best_found (r_found),
        .i_best_stamp (r_best_stamp),
        .o_take       (w_take)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and write-back controls
    always_comb begin
        n_state  = r_state;
        st_we    = 1'b0;
        sq_we    = 1'b0;
        tm_we    = 1'b0;
        init_clr = 1'b0;
        waddr    = w_slot_ext[IW-1:0];
        st_wdata = r_key.status;
        sq_wdata = r_key.seq;
        tm_wdata = r_now;
        unique case (r_state)
            tst_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (tst_pkg::t_opcode'(i_s_tuser))
                        tst_pkg::OP_ALLOC, tst_pkg::OP_OLDEST,
                        tst_pkg::OP_FIND_SEQ: n_state = tst_pkg::S_SCAN;
                        default:              n_state = tst_pkg::S_WRITE;
                    endcase
                end
            end
            tst_pkg::S_SCAN: begin
                if (r_cnt == IW'(SLOTS - 1)) begin
                    n_state = tst_pkg::S_DRAIN;
                end
            end
            tst_pkg::S_DRAIN: begin
                n_state = tst_pkg::S_WRITE;
            end
            tst_pkg::S_WRITE: begin
                n_state = tst_pkg::S_DONE;
                unique case (r_key.op)
                    tst_pkg::OP_INIT: begin
                        init_clr = 1'b1;
                    end
                    tst_pkg::OP_ALLOC: begin
                        waddr    = r_hit;
                        st_we    = r_found;
                        st_wdata = tst_pkg::ST_PENDING;
                    end
                    tst_pkg::OP_FREE: begin
                        st_we    = w_in_range;
                        sq_we    = w_in_range;
                        tm_we    = w_in_range;
                        st_wdata = tst_pkg::ST_FREE;
                        sq_wdata = '0;
                        tm_wdata = '0;
                    end
                    tst_pkg::OP_SET_STATUS: begin
                        st_we = w_in_range;
                    end
                    tst_pkg::OP_SET_SEQ: begin
                        sq_we = w_in_range;
                    end
                    tst_pkg::OP_OLDEST: begin
                        waddr = r_hit;
                        tm_we = r_found;
                    end
                    default: begin
                        init_clr = 1'b0;
                    end
                endcase
            end
            tst_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = tst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tst_pkg::S_IDLE;
            end
        endcase
    end

    // Word capture and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pipe_vld <= 1'b0;
        end else begin
            r_pipe_vld <= (r_state == tst_pkg::S_SCAN);
            if (r_state == tst_pkg::S_SCAN) begin
                r_cnt <= (r_cnt == IW'(SLOTS - 1)) ? '0 : r_cnt + 1'b1;
            end
        end
        if (w_accept) begin
            r_key.op      <= tst_pkg::t_opcode'(i_s_tuser);
            r_slot        <= i_s_tdata[3:0];
            r_key.status  <= i_s_tdata[6:4];
            r_key.seq     <= i_s_tdata[14:7];
            r_key.skip    <= i_s_tdata[18:15];
            r_key.skip_on <= i_s_tdata[19];
            r_now         <= STAMP_BITS'(i_s_tdata[51:20]);
        end
        r_pipe_idx <= r_cnt;
        r_pipe_stv <= r_st_vld[r_cnt];
        r_pipe_sqv <= r_sq_vld[r_cnt];
        r_pipe_tmv <= r_tm_vld[r_cnt];
    end

    // Running pick of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_hit   <= '0;
        end else if (w_accept) begin
            r_found <= 1'b0;
            r_hit   <= '0;
        end else if (r_pipe_vld && w_take) begin
            r_found <= 1'b1;
            r_hit   <= r_pipe_idx;
        end
        if (r_pipe_vld && w_take) begin
            r_best_stamp <= w_row_stamp;
        end
    end

    // Per-slot written marks; init drops only the status marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= '0;
            r_sq_vld <= '0;
            r_tm_vld <= '0;
        end else begin
            if (init_clr) begin
                r_st_vld <= '0;
            end else if (st_we) begin
                r_st_vld[waddr] <= 1'b1;
            end
            if (sq_we) begin
                r_sq_vld[waddr] <= 1'b1;
            end
            if (tm_we) begin
                r_tm_vld[waddr] <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == tst_pkg::S_DONE && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (r_state == tst_pkg::S_DONE && w_out_free) begin
            r_out_found <= r_found;
            r_out_idx   <= w_hit_ext[tst_pkg::IDX_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_found;
    assign o_m_tdata  = tst_pkg::OUT_TDATA_W'(r_out_idx);

`ifndef SYNTHESIS
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tst_pkg::S_WRITE && r_key.op == tst_pkg::OP_INIT) |=> (r_st_vld == '0))
        else $error("init left a slot marked in use");

    a_nosearch_nofound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tst_pkg::S_DONE && r_key.op != tst_pkg::OP_ALLOC &&
         r_key.op != tst_pkg::OP_OLDEST && r_key.op != tst_pkg::OP_FIND_SEQ) |-> !r_found)
        else $error("non-search word reports a hit");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("miss carries a nonzero index");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_vld |-> (r_state == tst_pkg::S_SCAN || r_state == tst_pkg::S_DRAIN))
        else $error("slot compare outside of a scan");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS      = tst_pkg::SLOTS_DEF;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_WORDS   = 1680;
    localparam int DRAIN_CYCLES   = 40;
    // Long receiver hold-off, so that the table backs up into its input
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 400;

    // Opcode 7 has no enum member; the table must leave all state alone
    localparam logic [tst_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [tst_pkg::OP_W-1:0]     op;
        logic [tst_pkg::IDX_W-1:0]    slot;
        logic [tst_pkg::STATUS_W-1:0] status;
        logic [tst_pkg::SEQ_W-1:0]    seq;
        logic [tst_pkg::IDX_W-1:0]    skip;
        logic                         skip_on;
        logic [tst_pkg::NOW_W-1:0]    now;
    } t_slot_cmd;

    typedef struct packed {
        logic                      found;
        logic [tst_pkg::IDX_W-1:0] idx;
    } t_slot_reply;

    typedef struct packed {
        t_slot_cmd   cmd;
        logic        typed;
        t_slot_reply want;
    } t_script_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_s_tvalid;
    logic                                o_s_tready;
    logic [tst_pkg::IN_TDATA_W-1:0]      i_s_tdata;
    logic [tst_pkg::OP_W-1:0]            i_s_tuser;
    logic                                o_m_tvalid;
    logic                                i_m_tready;
    logic [tst_pkg::OUT_TDATA_W-1:0]     o_m_tdata;
    logic                                o_m_tuser;

    transaction_slot_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Shadow copy of the slot pool
    logic [tst_pkg::STATUS_W-1:0]   pool_status [NUM_SLOTS];
    logic [tst_pkg::SEQ_W-1:0]      pool_seq    [NUM_SLOTS];
    logic [tst_pkg::NOW_W-1:0]      pool_stamp  [NUM_SLOTS];

    t_slot_reply           pending_replies [$];
    t_script_row           script_q [$];

    // Directed rows carry a hand-typed reply, picked up by the monitor on acceptance
    logic                  row_typed;
    t_slot_reply           row_want;

    int                    fail_count;
    int                    words_sent;
    int                    replies_checked;
    int                    refused_allocs;
    int                    search_hits;
    int                    op_count [8];
    int                    cycle_count;
    logic [tst_pkg::NOW_W-1:0] tick;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one command to the shadow pool and return its reply
    function automatic t_slot_reply pool_apply(input t_slot_cmd c);
        t_slot_reply r;
        r = '0;
        case (c.op)
            tst_pkg::OP_INIT: begin
                for (int i = 0; i < NUM_SLOTS; i++) pool_status[i] = tst_pkg::ST_FREE;
            end
            tst_pkg::OP_ALLOC: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!r.found && pool_status[i] == tst_pkg::ST_FREE) begin
                        pool_status[i] = tst_pkg::ST_PENDING;
                        r.found = 1'b1;
                        r.idx = i[tst_pkg::IDX_W-1:0];
                    end
                end
            end
            tst_pkg::OP_FREE: begin
                pool_status[c.slot] = tst_pkg::ST_FREE;
                pool_seq[c.slot] = '0;
                pool_stamp[c.slot] = '0;
            end
            tst_pkg::OP_SET_STATUS: pool_status[c.slot] = c.status;
            tst_pkg::OP_SET_SEQ:    pool_seq[c.slot] = c.seq;
            tst_pkg::OP_OLDEST: begin
                // strict less-than keeps the lowest index on equal stamps
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pool_status[i] == c.status &&
                        (!r.found || pool_stamp[i] < pool_stamp[r.idx])) begin
                        r.found = 1'b1;
                        r.idx = i[tst_pkg::IDX_W-1:0];
                    end
                end
                if (r.found) pool_stamp[r.idx] = c.now;
            end
            tst_pkg::OP_FIND_SEQ: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!r.found && !(c.skip_on && i == c.skip) &&
                        pool_status[i] != tst_pkg::ST_FREE && pool_seq[i] == c.seq) begin
                        r.found = 1'b1;
                        r.idx = i[tst_pkg::IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [tst_pkg::OP_W-1:0] op, input int slot,
                                    input int status, input int seq, input int skip,
                                    input int skip_on, input logic [tst_pkg::NOW_W-1:0] now,
                                    input int found, input int idx);
        t_script_row row;
        row.cmd = '{op, slot[tst_pkg::IDX_W-1:0], status[tst_pkg::STATUS_W-1:0],
                    seq[tst_pkg::SEQ_W-1:0], skip[tst_pkg::IDX_W-1:0], skip_on[0], now};
        row.typed = 1'b1;
        row.want = '{found[0], idx[tst_pkg::IDX_W-1:0]};
        script_q.push_back(row);
    endfunction

    // Random command; the mix shifts every 64 words between plain, fill and drain phases
    function automatic t_slot_cmd random_cmd(input int n);
        t_slot_cmd c;
        int r;
        int phase;
        r = $urandom_range(0, 99);
        phase = (n / 64) % 4;
        if (phase == 1) begin
            // fill: enough allocs to run the pool full
            if (r < 70)      c.op = tst_pkg::OP_ALLOC;
            else if (r < 80) c.op = tst_pkg::OP_SET_SEQ;
            else if (r < 90) c.op = tst_pkg::OP_FIND_SEQ;
            else             c.op = tst_pkg::OP_OLDEST;
        end else if (phase == 3) begin
            if (r < 40)      c.op = tst_pkg::OP_FREE;
            else if (r < 45) c.op = tst_pkg::OP_INIT;
            else if (r < 60) c.op = tst_pkg::OP_SET_STATUS;
            else if (r < 80) c.op = tst_pkg::OP_OLDEST;
            else             c.op = tst_pkg::OP_FIND_SEQ;
        end else begin
            if (r < 3)       c.op = tst_pkg::OP_INIT;
            else if (r < 6)  c.op = OP_UNUSED;
            else if (r < 26) c.op = tst_pkg::OP_ALLOC;
            else if (r < 38) c.op = tst_pkg::OP_FREE;
            else if (r < 50) c.op = tst_pkg::OP_SET_STATUS;
            else if (r < 64) c.op = tst_pkg::OP_SET_SEQ;
            else if (r < 80) c.op = tst_pkg::OP_OLDEST;
            else             c.op = tst_pkg::OP_FIND_SEQ;
        end
        c.slot    = tst_pkg::IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        c.status  = tst_pkg::STATUS_W'(($urandom_range(0, 99) < 80) ?
                                       $urandom_range(0, 3) : $urandom_range(0, 7));
        // a narrow sequence range makes matches common
        c.seq     = tst_pkg::SEQ_W'(($urandom_range(0, 99) < 75) ?
                                    $urandom_range(0, 3) : $urandom_range(0, 255));
        c.skip    = tst_pkg::IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        c.skip_on = 1'($urandom_range(0, 1));
        // mostly a slow tick with repeats (stamp ties), some wild values and extremes
        r = $urandom_range(0, 99);
        tick = tick + tst_pkg::NOW_W'($urandom_range(0, 3));
        if (r < 70)      c.now = tick;
        else if (r < 90) c.now = tst_pkg::NOW_W'($urandom);
        else if (r < 95) c.now = '0;
        else             c.now = '1;
        return c;
    endfunction

    // Send one word; entered and left at a falling edge
    task automatic send_word(input t_slot_cmd c, input logic typed, input t_slot_reply want);
        int gap;
        // every third stretch of 128 words goes back to back
        gap = ((words_sent / 128) % 3 == 2) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {{(tst_pkg::IN_TDATA_W - 52){1'b0}}, c.now, c.skip_on, c.skip, c.seq,
                       c.status, c.slot};
        i_s_tuser  <= c.op;
        row_typed  <= typed;
        row_want   <= want;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_script_row row;
        t_slot_reply none;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        row_typed  = 1'b0;
        row_want   = '0;
        none       = '0;
        tick       = '0;
        words_sent = 0;

        //      op                      slot st  seq    skip on  now           found idx
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'h00, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_OLDEST,     0,   0,  8'h00, 0,   0,  32'hFFFFFFFF, 1,    0);
        add_row(tst_pkg::OP_OLDEST,     0,   0,  8'h00, 0,   0,  32'h0,        1,    1);
        add_row(tst_pkg::OP_ALLOC,      0,   0,  8'h00, 0,   0,  32'h0,        1,    0);
        add_row(tst_pkg::OP_ALLOC,      0,   0,  8'h00, 0,   0,  32'h0,        1,    1);
        add_row(tst_pkg::OP_SET_SEQ,    1,   0,  8'hFF, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'hFF, 0,   0,  32'h0,        1,    1);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'hFF, 1,   1,  32'h0,        0,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'h00, 0,   0,  32'h0,        1,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'h00, 0,   1,  32'h0,        0,    0);
        add_row(tst_pkg::OP_SET_STATUS, 15,  7,  8'h00, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_OLDEST,     0,   7,  8'h00, 0,   0,  32'h12345678, 1,    15);
        add_row(tst_pkg::OP_SET_SEQ,    15,  0,  8'hFF, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'hFF, 1,   1,  32'h0,        1,    15);
        // pending slots 0 and 1: slot 1 carries the older stamp
        add_row(tst_pkg::OP_OLDEST,     0,   1,  8'h00, 0,   0,  32'hA5A5A5A5, 1,    1);
        add_row(tst_pkg::OP_FREE,       1,   0,  8'h00, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'hFF, 0,   0,  32'h0,        1,    15);
        // init frees the status only; slot 15 keeps its sequence
        add_row(tst_pkg::OP_INIT,       0,   0,  8'h00, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_SET_STATUS, 15,  2,  8'h00, 0,   0,  32'h0,        0,    0);
        add_row(tst_pkg::OP_FIND_SEQ,   0,   0,  8'hFF, 0,   0,  32'h0,        1,    15);
        add_row(tst_pkg::OP_OLDEST,     0,   2,  8'h00, 0,   0,  32'h5A5A5A5A, 1,    15);
        add_row(OP_UNUSED,              3,   5,  8'h81, 15,  1,  32'hFFFFFFFF, 0,    0);
        add_row(tst_pkg::OP_OLDEST,     0,   0,  8'h00, 0,   0,  32'h1,        1,    1);
        add_row(tst_pkg::OP_ALLOC,      0,   0,  8'h00, 0,   0,  32'h0,        1,    0);
        add_row(tst_pkg::OP_OLDEST,     0,   3,  8'h00, 0,   0,  32'h0,        0,    0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script_q[k]) begin
            row = script_q[k];
            send_word(row.cmd, row.typed, row.want);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) send_word(random_cmd(n), 1'b0, none);
        i_s_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words (init %0d, alloc %0d, free %0d, set status %0d, set seq %0d,",
                 words_sent, op_count[tst_pkg::OP_INIT], op_count[tst_pkg::OP_ALLOC],
                 op_count[tst_pkg::OP_FREE], op_count[tst_pkg::OP_SET_STATUS],
                 op_count[tst_pkg::OP_SET_SEQ]);
        $display("oldest %0d, find %0d, unused %0d); %0d replies, %0d hits, %0d allocs on full pool",
                 op_count[tst_pkg::OP_OLDEST], op_count[tst_pkg::OP_FIND_SEQ],
                 op_count[OP_UNUSED], replies_checked, search_hits, refused_allocs);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: random stall per word, one long hold-off to back up the table
    initial begin
        int rx_count;
        int rx_wait;
        i_m_tready = 1'b0;
        rx_count = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_wait = ((rx_count / 100) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (rx_count == HOLD_AT_RESULT) rx_wait = HOLD_CYCLES;
            if (rx_wait > 0) begin
                i_m_tready <= 1'b0;
                repeat (rx_wait) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            rx_count++;
        end
    end

    // Monitor: check results in order, predict on every accepted word
    always @(posedge i_clk) begin : monitor
        t_slot_cmd   c;
        t_slot_reply want;
        t_slot_reply model;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result word, found %0b index %0d", $time,
                             o_m_tuser, o_m_tdata[tst_pkg::IDX_W-1:0]);
                    fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (o_m_tuser !== want.found) begin
                        $display("%0t: found mismatch, expected %0b actual %0b", $time,
                                 want.found, o_m_tuser);
                        fail_count++;
                    end
                    if (o_m_tdata[tst_pkg::IDX_W-1:0] !== want.idx) begin
                        $display("%0t: index mismatch, expected %0d actual %0d", $time,
                                 want.idx, o_m_tdata[tst_pkg::IDX_W-1:0]);
                        fail_count++;
                    end
                    if (o_m_tdata[tst_pkg::OUT_TDATA_W-1:tst_pkg::IDX_W] !== '0) begin
                        $display("%0t: tdata padding, expected 0 actual %h", $time,
                                 o_m_tdata[tst_pkg::OUT_TDATA_W-1:tst_pkg::IDX_W]);
                        fail_count++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                c.op      = i_s_tuser;
                c.slot    = i_s_tdata[3:0];
                c.status  = i_s_tdata[6:4];
                c.seq     = i_s_tdata[14:7];
                c.skip    = i_s_tdata[18:15];
                c.skip_on = i_s_tdata[19];
                c.now     = i_s_tdata[51:20];
                model = pool_apply(c);
                op_count[c.op]++;
                if (c.op == tst_pkg::OP_ALLOC && !model.found) refused_allocs++;
                if (model.found) search_hits++;
                pending_replies.push_back(row_typed ? row_want : model);
            end
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                pool_status[i] = tst_pkg::ST_FREE;
                pool_seq[i]    = '0;
                pool_stamp[i]  = '0;
            end
            fail_count      = 0;
            replies_checked = 0;
            refused_allocs  = 0;
            search_hits     = 0;
            foreach (op_count[k]) op_count[k] = 0;
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                         cycle_count, pending_replies.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

### files.f
rtl/core/tst_pkg.sv
rtl/core/tst_ram.sv
rtl/core/tst_cmp.sv
rtl/core/transaction_slot_table.sv
bench/tb_top.sv
